// ===== hdl/srq_pkg.sv =====
package srq_pkg;

  localparam int unsigned ID_W   = 8;
  localparam int unsigned PRIO_W = 8;
  localparam int unsigned OCC_W  = 6;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_POP    = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]   task_id;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [ID_W-1:0]  popped_id;
    logic             popped_valid;
    logic             dropped;
    logic [OCC_W-1:0] occupancy;
  } result_t;

endpackage

// ===== hdl/srq_ram.sv =====
module srq_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/srq_seq.sv =====
module srq_seq #(
  parameter int unsigned QUEUE_DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     ready,
  input  logic                     func,
  input  logic [srq_pkg::ID_W-1:0]   task_id,
  input  logic [srq_pkg::PRIO_W-1:0] task_priority,
  output logic                     done_valid,
  input  logic                     done_ready,
  output srq_pkg::result_t         result
);

  import srq_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ICMP  = 5'b00010,
    S_PLACE = 5'b00100,
    S_POP   = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     k_r, k_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic [PRIO_W-1:0] prio_r, prio_nxt;
  logic [ID_W-1:0]   pid_r, pid_nxt;
  logic              pvalid_r, pvalid_nxt;
  logic              drop_r, drop_nxt;

  logic              we;
  logic [AW-1:0]     waddr;
  entry_t            wdata;
  logic [AW-1:0]     raddr;
  logic [ENTRY_W-1:0] rdata_raw;
  entry_t            rdata;
  logic [CW-1:0]     k_dec;
  logic [CW-1:0]     k_inc;
  logic [CW-1:0]     k_start;
  logic              full;

  srq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_raw)
  );

  assign rdata   = entry_t'(rdata_raw);
  assign full    = (cnt_r == DEPTH_C);
  assign k_start = full ? DEPTH_C : cnt_r;
  assign k_dec   = k_r - ONE_C;
  assign k_inc   = k_r + ONE_C;

  always_comb begin
    state_nxt  = state_r;
    k_nxt      = k_r;
    cnt_nxt    = cnt_r;
    id_nxt     = id_r;
    prio_nxt   = prio_r;
    pid_nxt    = pid_r;
    pvalid_nxt = pvalid_r;
    drop_nxt   = drop_r;
    we         = 1'b0;
    waddr      = '0;
    wdata      = '0;
    raddr      = '0;
    ready      = 1'b0;
    done_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        ready = 1'b1;
        if (start) begin
          id_nxt     = task_id;
          prio_nxt   = task_priority;
          pid_nxt    = '0;
          pvalid_nxt = 1'b0;
          drop_nxt   = 1'b0;
          if (func == FUNC_POP) begin
            k_nxt = '0;
            if (cnt_r == '0) begin
              state_nxt = S_FIN;
            end else begin
              state_nxt = S_POP;
            end
          end else if (task_id == '0) begin
            state_nxt = S_FIN;
          end else begin
            // walk backward from the tail, shifting larger entries back
            k_nxt    = k_start;
            drop_nxt = full;
            if (!full) begin
              cnt_nxt = cnt_r + ONE_C;
            end
            if (k_start == '0) begin
              state_nxt = S_PLACE;
            end else begin
              raddr     = AW'(k_start - ONE_C);
              state_nxt = S_ICMP;
            end
          end
        end
      end
      S_ICMP: begin
        if (rdata.prio > prio_r) begin
          if (k_r != DEPTH_C) begin
            we    = 1'b1;
            waddr = k_r[AW-1:0];
            wdata = rdata;
          end
          k_nxt = k_dec;
          if (k_dec == '0) begin
            state_nxt = S_PLACE;
          end else begin
            raddr = AW'(k_dec - ONE_C);
          end
        end else begin
          // no larger entry ahead: the new task goes here; on a full queue where it sorts last, it is lost
          if (k_r != DEPTH_C) begin
            we            = 1'b1;
            waddr         = k_r[AW-1:0];
            wdata.task_id = id_r;
            wdata.prio    = prio_r;
          end
          state_nxt = S_FIN;
        end
      end
      S_PLACE: begin
        we            = 1'b1;
        waddr         = k_r[AW-1:0];
        wdata.task_id = id_r;
        wdata.prio    = prio_r;
        state_nxt     = S_FIN;
      end
      S_POP: begin
        if (k_r == '0) begin
          pid_nxt    = rdata.task_id;
          pvalid_nxt = 1'b1;
        end else begin
          we    = 1'b1;
          waddr = AW'(k_dec);
          wdata = rdata;
        end
        if (k_inc < cnt_r) begin
          k_nxt = k_inc;
          raddr = AW'(k_inc);
        end else begin
          cnt_nxt   = cnt_r - ONE_C;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        done_valid = 1'b1;
        if (done_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    // pop reads slot zero right at acceptance
    if (state_r == S_IDLE && start && func == FUNC_POP) begin
      raddr = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    k_r      <= k_nxt;
    id_r     <= id_nxt;
    prio_r   <= prio_nxt;
    pid_r    <= pid_nxt;
    pvalid_r <= pvalid_nxt;
    drop_r   <= drop_nxt;
  end

  assign result.popped_id    = pid_r;
  assign result.popped_valid = pvalid_r;
  assign result.dropped      = drop_r;
  assign result.occupancy    = OCC_W'(cnt_r);

endmodule

// ===== hdl/sorted_ready_queue_scheduler.sv =====
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready  | in_func, in_task_id, in_task_priority
// out     | output    | out_valid / out_ready| out_popped_id, out_popped_valid,
//         |           |                      | out_dropped, out_occupancy
//
// one compare unit and one ram write port and read port are stepped by the sequencer
// insert: walks back from the tail, moving each larger entry back, then writes the new task
// pop: reads slot zero, then moves every other queued task forward by one slot
// the ram needs no clearing pass, the fill count marks the live slots
// rst_n is synchronous; the next request is taken while a result waits
// on a stalled output, the sequencer holds its finished result until taken
module sorted_ready_queue_scheduler #(
  parameter int unsigned QUEUE_DEPTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_func,
  input  logic [srq_pkg::ID_W-1:0]     in_task_id,
  input  logic [srq_pkg::PRIO_W-1:0]   in_task_priority,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [srq_pkg::ID_W-1:0]     out_popped_id,
  output logic                         out_popped_valid,
  output logic                         out_dropped,
  output logic [srq_pkg::OCC_W-1:0]    out_occupancy
);

  import srq_pkg::*;

  logic    done_valid;
  logic    done_ready;
  result_t seq_result;
  result_t res_r, res_nxt;
  logic    out_valid_r, out_valid_nxt;

  srq_seq #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (in_valid),
    .ready         (in_ready),
    .func          (in_func),
    .task_id       (in_task_id),
    .task_priority (in_task_priority),
    .done_valid    (done_valid),
    .done_ready    (done_ready),
    .result        (seq_result)
  );

  assign done_ready = !out_valid_r || out_ready;

  always_comb begin
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (done_valid && done_ready) begin
      res_nxt       = seq_result;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    res_r <= res_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_popped_id    = res_r.popped_id;
  assign out_popped_valid = res_r.popped_valid;
  assign out_dropped      = res_r.dropped;
  assign out_occupancy    = res_r.occupancy;

endmodule

// ===== hdl/srq_checker.sv =====
module srq_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_func,
  input logic [srq_pkg::ID_W-1:0]   in_task_id,
  input logic [srq_pkg::PRIO_W-1:0] in_task_priority,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [srq_pkg::ID_W-1:0]   out_popped_id,
  input logic                       out_popped_valid,
  input logic                       out_dropped,
  input logic [srq_pkg::OCC_W-1:0]  out_occupancy
);

  // a returned task is never id zero, and no task means id zero
  a_pop_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_popped_valid == (out_popped_id != '0)))
    else $error("popped id and popped valid disagree");

  // one request never both pops and drops
  a_pop_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_popped_valid && out_dropped))
    else $error("pop and drop in one result");

  // a drop happens only on a full queue; this checks for a non-zero occupancy
  a_drop_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_dropped) |-> (out_occupancy != '0))
    else $error("drop reported with empty queue");

  // a stalled result holds its popped id and occupancy
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_popped_id)
      && $stable(out_occupancy)))
    else $error("result changed while stalled");

endmodule

bind sorted_ready_queue_scheduler srq_checker u_srq_checker (.*);
